[rtl/kev_pkg.sv]
// ----------------------------------------------------------------------------
// kev_pkg
// Shared types, constants and the function key sequence lookup for the
// key event to VT100 encoder.
// ----------------------------------------------------------------------------
package kev_pkg;

  localparam int VK_W   = 8;
  localparam int MOD_W  = 9;
  localparam int UNIT_W = 16;
  localparam int REP_W  = 16;
  localparam int SEQ_W  = 56;
  localparam int LEN_W  = 3;
  localparam int CP_W   = 21;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] VK_MENU  = 8'h12;

  localparam logic [UNIT_W-1:0] HS_LO  = 16'hD800;
  localparam logic [UNIT_W-1:0] LS_LO  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LS_END = 16'hE000;

  // Modifier bit positions
  localparam int MB_RALT  = 0;
  localparam int MB_LALT  = 1;
  localparam int MB_RCTRL = 2;
  localparam int MB_LCTRL = 3;
  localparam int MB_SHIFT = 4;
  localparam int MB_ENH   = 8;

  // Sequence variants
  localparam logic [1:0] SEL_PLAIN      = 2'd0;
  localparam logic [1:0] SEL_SHIFT      = 2'd1;
  localparam logic [1:0] SEL_CTRL       = 2'd2;
  localparam logic [1:0] SEL_SHIFT_CTRL = 2'd3;

  // Key families in the escape table
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TILDE  = 2'd1;
  localparam logic [1:0] KIND_LETTER = 2'd2;
  localparam logic [1:0] KIND_FKEY   = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic              key_down;
    logic [VK_W-1:0]   virtual_key;
    logic [MOD_W-1:0]  modifier_bits;
    logic [UNIT_W-1:0] utf16_unit;
    logic [REP_W-1:0]  repeat_count;
  } key_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_bytes;
    logic [LEN_W-1:0] seq_length;
    logic [REP_W-1:0] repeat_times;
  } seq_item_t;

  typedef struct packed {
    logic emit;
    logic pend_load;
    logic pend_clear;
  } enc_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [39:0]      bytes;
    logic [LEN_W-1:0] len;
  } key_seq_t;

  function automatic logic is_compose_key(input logic [VK_W-1:0] vk);
    logic r;
    unique case (vk)
      8'h2D, 8'h23, 8'h28, 8'h22, 8'h25,
      8'h0C, 8'h27, 8'h24, 8'h26, 8'h21: r = 1'b1;
      default: r = (vk >= 8'h60) && (vk <= 8'h69);
    endcase
    return r;
  endfunction

  // Escape sequence body without the leading ESC, first byte in bits 7..0.
  function automatic key_seq_t key_lookup(input logic [VK_W-1:0] vk,
                                          input logic [1:0] sel);
    key_seq_t    r;
    logic [1:0]  kind;
    logic [7:0]  c0;
    logic [15:0] sh_code;
    logic [15:0] ct_code;
    logic [7:0]  sh_term;
    logic [7:0]  sc_term;
    logic        low_fkey;
    logic [7:0]  mod_ch;
    kind     = KIND_NONE;
    c0       = 8'h00;
    sh_code  = "00";
    ct_code  = "00";
    sh_term  = "~";
    sc_term  = "^";
    low_fkey = 1'b0;
    unique case (vk)
      8'h2D, 8'h60: begin kind = KIND_TILDE;  c0 = "2"; end
      8'h23, 8'h61: begin kind = KIND_TILDE;  c0 = "4"; end
      8'h28, 8'h62: begin kind = KIND_LETTER; c0 = "B"; end
      8'h22, 8'h63: begin kind = KIND_TILDE;  c0 = "6"; end
      8'h25, 8'h64: begin kind = KIND_LETTER; c0 = "D"; end
      8'h0C, 8'h65: begin kind = KIND_LETTER; c0 = "G"; end
      8'h27, 8'h66: begin kind = KIND_LETTER; c0 = "C"; end
      8'h26, 8'h67: begin kind = KIND_LETTER; c0 = "A"; end
      8'h24, 8'h68: begin kind = KIND_TILDE;  c0 = "1"; end
      8'h21, 8'h69: begin kind = KIND_TILDE;  c0 = "5"; end
      8'h2E, 8'h6E: begin kind = KIND_TILDE;  c0 = "3"; end
      8'h70: begin kind = KIND_FKEY; low_fkey = 1'b1; c0 = "A"; sh_code = "23"; ct_code = "11"; end
      8'h71: begin kind = KIND_FKEY; low_fkey = 1'b1; c0 = "B"; sh_code = "24"; ct_code = "12"; end
      8'h72: begin kind = KIND_FKEY; low_fkey = 1'b1; c0 = "C"; sh_code = "25"; ct_code = "13"; end
      8'h73: begin kind = KIND_FKEY; low_fkey = 1'b1; c0 = "D"; sh_code = "26"; ct_code = "14"; end
      8'h74: begin kind = KIND_FKEY; low_fkey = 1'b1; c0 = "E"; sh_code = "28"; ct_code = "15"; end
      8'h75: begin kind = KIND_FKEY; sh_code = "29"; ct_code = "17"; end
      8'h76: begin kind = KIND_FKEY; sh_code = "31"; ct_code = "18"; end
      8'h77: begin kind = KIND_FKEY; sh_code = "32"; ct_code = "19"; end
      8'h78: begin kind = KIND_FKEY; sh_code = "33"; ct_code = "20"; end
      8'h79: begin kind = KIND_FKEY; sh_code = "34"; ct_code = "21"; end
      8'h7A: begin
        kind = KIND_FKEY; sh_code = "23"; ct_code = "23"; sh_term = "$"; sc_term = "@";
      end
      8'h7B: begin
        kind = KIND_FKEY; sh_code = "24"; ct_code = "24"; sh_term = "$"; sc_term = "@";
      end
      default: kind = KIND_NONE;
    endcase

    unique case (sel)
      SEL_SHIFT: mod_ch = "2";
      SEL_CTRL:  mod_ch = "5";
      default:   mod_ch = "6";
    endcase

    r.found = (kind != KIND_NONE);
    r.bytes = '0;
    r.len   = '0;
    unique case (kind)
      KIND_TILDE: begin
        if (sel == SEL_PLAIN) begin
          r.bytes = {16'h0000, 8'h7E, c0, 8'h5B};
          r.len   = 3'd3;
        end else begin
          r.bytes = {8'h7E, mod_ch, 8'h3B, c0, 8'h5B};
          r.len   = 3'd5;
        end
      end
      KIND_LETTER: begin
        if (sel == SEL_PLAIN) begin
          r.bytes = {24'h000000, c0, 8'h5B};
          r.len   = 3'd2;
        end else begin
          r.bytes = {c0, mod_ch, 8'h3B, 8'h31, 8'h5B};
          r.len   = 3'd5;
        end
      end
      KIND_FKEY: begin
        r.len = 3'd4;
        unique case (sel)
          SEL_PLAIN: begin
            if (low_fkey) begin
              r.bytes = {16'h0000, c0, 8'h5B, 8'h5B};
              r.len   = 3'd3;
            end else begin
              r.bytes = {8'h00, 8'h7E, ct_code[7:0], ct_code[15:8], 8'h5B};
            end
          end
          SEL_SHIFT: r.bytes = {8'h00, sh_term, sh_code[7:0], sh_code[15:8], 8'h5B};
          SEL_CTRL:  r.bytes = {8'h00, 8'h5E, ct_code[7:0], ct_code[15:8], 8'h5B};
          default:   r.bytes = {8'h00, sc_term, sh_code[7:0], sh_code[15:8], 8'h5B};
        endcase
      end
      default: begin
        r.bytes = '0;
        r.len   = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/kev_if.sv]
// ----------------------------------------------------------------------------
// kev_in_if / kev_out_if
// Valid/ready channels carrying key events in and escape sequences out.
// ----------------------------------------------------------------------------
interface kev_in_if
  import kev_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              key_down;
  logic [VK_W-1:0]   virtual_key;
  logic [MOD_W-1:0]  modifier_bits;
  logic [UNIT_W-1:0] utf16_unit;
  logic [REP_W-1:0]  repeat_count;

  modport source (
    output valid, cmd, key_down, virtual_key, modifier_bits, utf16_unit, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, key_down, virtual_key, modifier_bits, utf16_unit, repeat_count,
    output ready
  );
endinterface

interface kev_out_if
  import kev_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_bytes;
  logic [LEN_W-1:0] seq_length;
  logic [REP_W-1:0] repeat_times;

  modport source (
    output valid, seq_bytes, seq_length, repeat_times,
    input  ready
  );
  modport sink (
    input  valid, seq_bytes, seq_length, repeat_times,
    output ready
  );
endinterface

[rtl/kev_encode.sv]
// ----------------------------------------------------------------------------
// kev_encode
// Combinational encoder: filters one key event and builds its UTF-8 or
// VT100 byte sequence, using the pending high surrogate.
// ----------------------------------------------------------------------------
module kev_encode
  import kev_pkg::*;
(
  input  key_item_t         item,
  input  logic [UNIT_W-1:0] pend,
  output enc_ctrl_t         ctrl,
  output seq_item_t         res
);

  logic             l_alt, any_alt, any_ctrl, shift, enh;
  logic             has_unit, is_high, is_low, pend_ok, drop;
  logic [CP_W-1:0]  cp;
  logic [31:0]      u8_bytes;
  logic [LEN_W-1:0] u8_len;
  logic             chr_esc;
  logic [1:0]       sel;
  key_seq_t         kseq;
  logic [47:0]      key_base;

  assign l_alt    = item.modifier_bits[MB_LALT];
  assign any_alt  = item.modifier_bits[MB_LALT] | item.modifier_bits[MB_RALT];
  assign any_ctrl = item.modifier_bits[MB_LCTRL] | item.modifier_bits[MB_RCTRL];
  assign shift    = item.modifier_bits[MB_SHIFT];
  assign enh      = item.modifier_bits[MB_ENH];

  assign has_unit = (item.utf16_unit != '0);
  assign is_high  = (item.utf16_unit >= HS_LO) && (item.utf16_unit < LS_LO);
  assign is_low   = (item.utf16_unit >= LS_LO) && (item.utf16_unit < LS_END);
  assign pend_ok  = (pend >= HS_LO) && (pend < LS_LO);

  // Drop other events, plain releases and alt-numpad compose keys
  assign drop = item.cmd
              | (~item.key_down & ~((l_alt | (item.virtual_key == VK_MENU)) & has_unit))
              | (l_alt & ~enh & is_compose_key(item.virtual_key));

  always_comb begin
    if (is_low) begin
      if (pend_ok) begin
        cp = 21'h10000 + {1'b0, pend[9:0], item.utf16_unit[9:0]};
      end else begin
        cp = 21'h00FFFD;
      end
    end else begin
      cp = {5'd0, item.utf16_unit};
    end
  end

  always_comb begin
    priority if (cp < 21'h80) begin
      u8_bytes = {24'h0, cp[7:0]};
      u8_len   = 3'd1;
    end else if (cp < 21'h800) begin
      u8_bytes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      u8_len   = 3'd2;
    end else if (cp < 21'h10000) begin
      u8_bytes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      u8_len   = 3'd3;
    end else begin
      u8_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      u8_len   = 3'd4;
    end
  end

  assign chr_esc  = any_alt & ~any_ctrl & item.key_down;
  assign sel      = {any_ctrl, shift};
  assign kseq     = key_lookup(item.virtual_key, sel);
  assign key_base = {kseq.bytes, ESC_BYTE};

  always_comb begin
    ctrl.emit       = 1'b0;
    ctrl.pend_load  = 1'b0;
    ctrl.pend_clear = 1'b0;
    res.seq_bytes   = '0;
    res.seq_length  = '0;
    res.repeat_times = (item.repeat_count == '0) ? REP_W'(1) : item.repeat_count;
    if (!drop) begin
      if (has_unit) begin
        if (is_high) begin
          ctrl.pend_load = 1'b1;
        end else begin
          ctrl.emit       = 1'b1;
          ctrl.pend_clear = 1'b1;
          if (chr_esc) begin
            res.seq_bytes  = {16'h0, u8_bytes, ESC_BYTE};
            res.seq_length = u8_len + 3'd1;
          end else begin
            res.seq_bytes  = {24'h0, u8_bytes};
            res.seq_length = u8_len;
          end
        end
      end else if (kseq.found) begin
        ctrl.emit = 1'b1;
        if (any_alt) begin
          res.seq_bytes  = {key_base, ESC_BYTE};
          res.seq_length = kseq.len + 3'd2;
        end else begin
          res.seq_bytes  = {8'h0, key_base};
          res.seq_length = kseq.len + 3'd1;
        end
      end
    end
  end

endmodule

[rtl/key_event_to_vt100_encoder_top.sv]
// ----------------------------------------------------------------------------
// key_event_to_vt100_encoder_top
// Turns console key events into UTF-8 or VT100 escape byte sequences.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    cmd, key_down, virtual_key, modifier_bits,
//                                   utf16_unit, repeat_count
//  out_ch    out   valid / ready    seq_bytes, seq_length, repeat_times
//
//  One item per cycle sustained while out_ch takes results. An accepted item
//  sits in the input register, is encoded there and moves into the result
//  register once the result slot is free; out_ch.valid follows that register.
//  Reset (rst_n low, synchronous) empties both stages and clears the pending
//  high surrogate.
//  A stalled result holds the result register; the input register takes an
//  item only while it is empty and holds it until the result slot frees.
// ----------------------------------------------------------------------------
module key_event_to_vt100_encoder_top
  import kev_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  kev_in_if.sink        in_ch,
  kev_out_if.source     out_ch
);

  logic              s1_valid_r, s1_valid_nxt;
  key_item_t         s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  seq_item_t         out_item_r;
  logic [UNIT_W-1:0] pend_r, pend_nxt;

  logic      in_fire, out_free, s1_adv;
  key_item_t in_item;
  enc_ctrl_t enc_ctrl;
  seq_item_t enc_res;

  // Gather the incoming item
  assign in_item = '{
    cmd:           in_ch.cmd,
    key_down:      in_ch.key_down,
    virtual_key:   in_ch.virtual_key,
    modifier_bits: in_ch.modifier_bits,
    utf16_unit:    in_ch.utf16_unit,
    repeat_count:  in_ch.repeat_count
  };

  // The result slot is free when empty or being taken this cycle
  assign out_free    = ~out_valid_r | out_ch.ready;
  assign s1_adv      = s1_valid_r & out_free;
  assign in_ch.ready = ~s1_valid_r | out_free;
  assign in_fire     = in_ch.valid & in_ch.ready;

  kev_encode u_encode (
    .item (s1_item_r),
    .pend (pend_r),
    .ctrl (enc_ctrl),
    .res  (enc_res)
  );

  always_comb begin
    // advance the input stage
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    // load a result or drop the one just taken
    if (s1_adv) begin
      out_valid_nxt = enc_ctrl.emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    // pending high surrogate changes only as an item leaves the input stage
    if (s1_adv && enc_ctrl.pend_load) begin
      pend_nxt = s1_item_r.utf16_unit;
    end else if (s1_adv && enc_ctrl.pend_clear) begin
      pend_nxt = '0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_adv && enc_ctrl.emit) begin
      out_item_r <= enc_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.seq_bytes    = out_item_r.seq_bytes;
  assign out_ch.seq_length   = out_item_r.seq_length;
  assign out_ch.repeat_times = out_item_r.repeat_times;

endmodule

[tb/key_event_to_vt100_encoder_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_to_vt100_encoder_top_tb
// Self-checking bench for the key event to VT100 encoder. A short table of
// hand-picked events runs first, then a long stream of random key events.
// Each accepted event is run through a local encoder model, and every item
// that leaves the block is matched against the oldest owed sequence.
// ----------------------------------------------------------------------------
module key_event_to_vt100_encoder_top_tb;
  import kev_pkg::*;

  // Event kinds on the cmd field
  localparam logic EV_KEY   = 1'b0;
  localparam logic EV_OTHER = 1'b1;

  // Modifier masks, built from the package bit positions
  localparam logic [MOD_W-1:0] M_RALT  = 9'b1 << MB_RALT;
  localparam logic [MOD_W-1:0] M_LALT  = 9'b1 << MB_LALT;
  localparam logic [MOD_W-1:0] M_RCTRL = 9'b1 << MB_RCTRL;
  localparam logic [MOD_W-1:0] M_LCTRL = 9'b1 << MB_LCTRL;
  localparam logic [MOD_W-1:0] M_SHIFT = 9'b1 << MB_SHIFT;
  localparam logic [MOD_W-1:0] M_ENH   = 9'b1 << MB_ENH;

  // A few key codes used by the directed table
  localparam logic [7:0] VK_PAD_CENTER = 8'h0C;
  localparam logic [7:0] VK_INS   = 8'h2D;
  localparam logic [7:0] VK_UP    = 8'h26;
  localparam logic [7:0] VK_DEL   = 8'h2E;
  localparam logic [7:0] VK_NUM0  = 8'h60;
  localparam logic [7:0] VK_NUM4  = 8'h64;
  localparam logic [7:0] VK_F1    = 8'h70;
  localparam logic [7:0] VK_F5    = 8'h74;
  localparam logic [7:0] VK_F12   = 8'h7B;
  localparam logic [7:0] VK_A     = 8'h41;
  localparam logic [7:0] VK_C     = 8'h43;

  localparam int PLAN_ROWS    = 26;
  localparam int RANDOM_KEYS  = 1350;
  localparam int DRAIN_CYCLES = 8;   // two-stage pipe, plus margin
  localparam int PRINT_CAP    = 100;

  // One row of the directed table. When 'typed' is set, the expectation is
  // taken from 'yields'/'want'; otherwise the encoder model decides.
  typedef struct packed {
    key_item_t ev;
    logic      typed;
    logic      yields;
    seq_item_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kev_in_if  in_ch ();
  kev_out_if out_ch ();

  key_event_to_vt100_encoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The 34 keys that have an escape sequence
  logic [7:0] mapped_keys [34] = '{
    8'h2D, 8'h23, 8'h28, 8'h22, 8'h25, 8'h0C, 8'h27, 8'h26, 8'h24, 8'h21, 8'h2E,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6E,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
    8'h7B
  };

  // Model state: the high half of a surrogate pair waiting for its low half
  logic [UNIT_W-1:0] held_high_half;

  // Sequences the block still owes, oldest first
  seq_item_t owed_sequences [$];

  plan_row_t   plan [PLAN_ROWS];
  int unsigned idle_pct = 18;
  int          fail_count = 0;
  int          key_items = 0;
  int          other_events = 0;
  int          sequences_checked = 0;
  int          surrogate_pairs = 0;
  seq_item_t   oldest;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Encoder model
  // --------------------------------------------------------------------------

  // Left alt plus one of these (not enhanced) is an alt+numpad compose, dropped
  function automatic logic alt_compose_key(input logic [7:0] vk);
    case (vk)
      8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h2D, 8'h0C:
        return 1'b1;
      default:
        return (vk >= 8'h60) && (vk <= 8'h69);
    endcase
  endfunction

  // Escape sequence body after the leading ESC; empty for unmapped keys
  function automatic string vt100_tail(input logic [7:0] vk, input logic [1:0] variant);
    string row [4];
    case (vk)
      8'h2D, 8'h60: row = '{"[2~",  "[2;2~", "[2;5~", "[2;6~"};
      8'h23, 8'h61: row = '{"[4~",  "[4;2~", "[4;5~", "[4;6~"};
      8'h28, 8'h62: row = '{"[B",   "[1;2B", "[1;5B", "[1;6B"};
      8'h22, 8'h63: row = '{"[6~",  "[6;2~", "[6;5~", "[6;6~"};
      8'h25, 8'h64: row = '{"[D",   "[1;2D", "[1;5D", "[1;6D"};
      8'h0C, 8'h65: row = '{"[G",   "[1;2G", "[1;5G", "[1;6G"};
      8'h27, 8'h66: row = '{"[C",   "[1;2C", "[1;5C", "[1;6C"};
      8'h26, 8'h67: row = '{"[A",   "[1;2A", "[1;5A", "[1;6A"};
      8'h24, 8'h68: row = '{"[1~",  "[1;2~", "[1;5~", "[1;6~"};
      8'h21, 8'h69: row = '{"[5~",  "[5;2~", "[5;5~", "[5;6~"};
      8'h2E, 8'h6E: row = '{"[3~",  "[3;2~", "[3;5~", "[3;6~"};
      8'h70:        row = '{"[[A",  "[23~",  "[11^",  "[23^"};
      8'h71:        row = '{"[[B",  "[24~",  "[12^",  "[24^"};
      8'h72:        row = '{"[[C",  "[25~",  "[13^",  "[25^"};
      8'h73:        row = '{"[[D",  "[26~",  "[14^",  "[26^"};
      8'h74:        row = '{"[[E",  "[28~",  "[15^",  "[28^"};
      8'h75:        row = '{"[17~", "[29~",  "[17^",  "[29^"};
      8'h76:        row = '{"[18~", "[31~",  "[18^",  "[31^"};
      8'h77:        row = '{"[19~", "[32~",  "[19^",  "[32^"};
      8'h78:        row = '{"[20~", "[33~",  "[20^",  "[33^"};
      8'h79:        row = '{"[21~", "[34~",  "[21^",  "[34^"};
      8'h7A:        row = '{"[23~", "[23$",  "[23^",  "[23@"};
      8'h7B:        row = '{"[24~", "[24$",  "[24^",  "[24@"};
      default:      row = '{"", "", "", ""};
    endcase
    return row[variant];
  endfunction

  // Append a byte; anything past seven bytes is dropped
  function automatic void push_byte(inout logic [SEQ_W-1:0] acc, inout int n,
                                    input logic [7:0] b);
    if (n < 7) begin
      acc[8*n +: 8] = b;
      n++;
    end
  endfunction

  function automatic void push_utf8(inout logic [SEQ_W-1:0] acc, inout int n,
                                    input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      push_byte(acc, n, cp[7:0]);
    end else if (cp < 21'h800) begin
      push_byte(acc, n, {3'b110, cp[10:6]});
      push_byte(acc, n, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_byte(acc, n, {4'b1110, cp[15:12]});
      push_byte(acc, n, {2'b10, cp[11:6]});
      push_byte(acc, n, {2'b10, cp[5:0]});
    end else begin
      push_byte(acc, n, {5'b11110, cp[20:18]});
      push_byte(acc, n, {2'b10, cp[17:12]});
      push_byte(acc, n, {2'b10, cp[11:6]});
      push_byte(acc, n, {2'b10, cp[5:0]});
    end
  endfunction

  // Returns 1 when the event yields a sequence, which is then left in 'seq'.
  // Updates held_high_half as the block would.
  function automatic logic encode_key_event(input key_item_t ev, output seq_item_t seq);
    logic [SEQ_W-1:0]  acc;
    int                n;
    logic              l_alt;
    logic              alt;
    logic              ctrl;
    logic              shf;
    logic              enh;
    logic [1:0]        variant;
    logic [CP_W-1:0]   cp;
    logic [UNIT_W-1:0] u;
    string             tail;
    acc   = '0;
    n     = 0;
    seq   = '0;
    u     = ev.utf16_unit;
    l_alt = ev.modifier_bits[MB_LALT];
    alt   = l_alt | ev.modifier_bits[MB_RALT];
    ctrl  = ev.modifier_bits[MB_RCTRL] | ev.modifier_bits[MB_LCTRL];
    shf   = ev.modifier_bits[MB_SHIFT];
    enh   = ev.modifier_bits[MB_ENH];

    if (ev.cmd != EV_KEY)
      return 1'b0;
    // releases pass only with a character and left alt or the menu key
    if (!ev.key_down && !((l_alt || ev.virtual_key == VK_MENU) && u != '0))
      return 1'b0;
    if (l_alt && !enh && alt_compose_key(ev.virtual_key))
      return 1'b0;

    if (u != '0) begin
      if (u >= HS_LO && u < LS_LO) begin
        held_high_half = u;
        return 1'b0;
      end
      if (alt && !ctrl && ev.key_down)
        push_byte(acc, n, ESC_BYTE);
      if (u >= LS_LO && u < LS_END) begin
        if (held_high_half >= HS_LO && held_high_half < LS_LO)
          cp = 21'h10000 + {1'b0, held_high_half[9:0], u[9:0]};
        else
          cp = 21'hFFFD;   // orphan low half becomes the replacement char
      end else begin
        cp = {5'b0, u};
      end
      push_utf8(acc, n, cp);
      held_high_half = '0;
    end else begin
      if (shf)
        variant = ctrl ? SEL_SHIFT_CTRL : SEL_SHIFT;
      else
        variant = ctrl ? SEL_CTRL : SEL_PLAIN;
      tail = vt100_tail(ev.virtual_key, variant);
      if (tail.len() == 0)
        return 1'b0;
      // key path: any alt gives the extra ESC, ctrl or not
      if (alt)
        push_byte(acc, n, ESC_BYTE);
      push_byte(acc, n, ESC_BYTE);
      for (int i = 0; i < tail.len(); i++)
        push_byte(acc, n, tail[i]);
    end

    seq.seq_bytes    = acc;
    seq.seq_length   = n[LEN_W-1:0];
    seq.repeat_times = (ev.repeat_count == '0) ? 16'd1 : ev.repeat_count;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic key_item_t mk(input logic cmd, input logic down,
                                   input logic [7:0] vk, input logic [MOD_W-1:0] mods,
                                   input logic [UNIT_W-1:0] unit,
                                   input logic [REP_W-1:0] rep);
    key_item_t k;
    k.cmd           = cmd;
    k.key_down      = down;
    k.virtual_key   = vk;
    k.modifier_bits = mods;
    k.utf16_unit    = unit;
    k.repeat_count  = rep;
    return k;
  endfunction

  function automatic plan_row_t by_model(input key_item_t ev);
    plan_row_t r;
    r.ev     = ev;
    r.typed  = 1'b0;
    r.yields = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_in(input key_item_t ev, input logic yields,
                                         input logic [SEQ_W-1:0] bytes,
                                         input logic [LEN_W-1:0] len,
                                         input logic [REP_W-1:0] reps);
    plan_row_t r;
    r.ev                = ev;
    r.typed             = 1'b1;
    r.yields            = yields;
    r.want.seq_bytes    = bytes;
    r.want.seq_length   = len;
    r.want.repeat_times = reps;
    return r;
  endfunction

  function automatic logic [MOD_W-1:0] rand_mods();
    return MOD_W'($urandom_range(0, 511));
  endfunction

  // Repeat counts lean toward the corners: zero, one and all ones
  function automatic logic [REP_W-1:0] rand_rep();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return 16'h0000;
    if (pick == 1)
      return 16'hFFFF;
    if (pick < 5)
      return 16'h0001;
    return REP_W'($urandom_range(0, 65535));
  endfunction

  // A non-surrogate character from one of the one- to three-byte UTF-8 length classes
  function automatic logic [UNIT_W-1:0] rand_char();
    case ($urandom_range(0, 3))
      0:       return UNIT_W'($urandom_range(16'h0001, 16'h007F));
      1:       return UNIT_W'($urandom_range(16'h0080, 16'h07FF));
      2:       return UNIT_W'($urandom_range(16'h0800, 16'hD7FF));
      default: return UNIT_W'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  task automatic report_bad(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Offer one item on in_ch and hold it until taken. Valid stays high on
  // return so a back-to-back item does not touch it twice in one step.
  task automatic send_key(input key_item_t ev, input logic typed, input logic yields,
                          input seq_item_t want);
    seq_item_t seq;
    logic      has_seq;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= ev.cmd;
    in_ch.key_down      <= ev.key_down;
    in_ch.virtual_key   <= ev.virtual_key;
    in_ch.modifier_bits <= ev.modifier_bits;
    in_ch.utf16_unit    <= ev.utf16_unit;
    in_ch.repeat_count  <= ev.repeat_count;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    // taken at this edge: advance the model even for typed rows
    has_seq = encode_key_event(ev, seq);
    if (typed) begin
      has_seq = yields;
      seq     = want;
    end
    if (has_seq)
      owed_sequences.push_back(seq);
    if (ev.cmd == EV_KEY)
      key_items++;
    else
      other_events++;
  endtask

  // One random burst: mostly well-formed key traffic, some raw noise
  task automatic random_burst();
    int unsigned pick;
    key_item_t   k;
    pick = $urandom_range(0, 99);
    k = mk(EV_KEY, 1'b1, 8'($urandom_range(0, 255)), rand_mods(), 16'h0000, rand_rep());
    if (pick < 30) begin
      // plain character, now and then on release
      k.utf16_unit = rand_char();
      k.key_down   = ($urandom_range(0, 9) != 0);
      send_key(k, 1'b0, 1'b0, '0);
    end else if (pick < 45) begin
      // surrogate pair, sometimes split by a key that must not clear the high half
      k.utf16_unit = UNIT_W'($urandom_range(16'hD800, 16'hDBFF));
      send_key(k, 1'b0, 1'b0, '0);
      if ($urandom_range(0, 3) == 0) begin
        k.utf16_unit  = '0;
        k.virtual_key = mapped_keys[$urandom_range(0, 33)];
        send_key(k, 1'b0, 1'b0, '0);
      end
      k.virtual_key   = 8'($urandom_range(0, 255));
      k.modifier_bits = rand_mods();
      k.utf16_unit    = UNIT_W'($urandom_range(16'hDC00, 16'hDFFF));
      k.repeat_count  = rand_rep();
      send_key(k, 1'b0, 1'b0, '0);
      surrogate_pairs++;
    end else if (pick < 70) begin
      // navigation, keypad or function key
      k.virtual_key = mapped_keys[$urandom_range(0, 33)];
      send_key(k, 1'b0, 1'b0, '0);
    end else if (pick < 80) begin
      // release, with the conditions that let it through often present
      k.key_down = 1'b0;
      if ($urandom_range(0, 1) == 0)
        k.virtual_key = VK_MENU;
      if ($urandom_range(0, 1) == 0)
        k.modifier_bits[MB_LALT] = 1'b1;
      k.utf16_unit = ($urandom_range(0, 1) == 0) ? rand_char()
                                                 : UNIT_W'($urandom_range(0, 65535));
      send_key(k, 1'b0, 1'b0, '0);
    end else if (pick < 95) begin
      // raw key event, with a bias toward orphan low halves
      k.key_down   = 1'($urandom_range(0, 1));
      k.utf16_unit = ($urandom_range(0, 3) == 0) ? UNIT_W'($urandom_range(16'hDC00, 16'hDFFF))
                                                 : UNIT_W'($urandom_range(0, 65535));
      send_key(k, 1'b0, 1'b0, '0);
    end else begin
      // non-key event, must vanish
      k.cmd        = EV_OTHER;
      k.key_down   = 1'($urandom_range(0, 1));
      k.utf16_unit = UNIT_W'($urandom_range(0, 65535));
      send_key(k, 1'b0, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order check
  // --------------------------------------------------------------------------

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sequences_checked++;
      if (owed_sequences.size() == 0) begin
        report_bad($sformatf("unexpected item bytes=%h len=%0d rep=%0d",
                             out_ch.seq_bytes, out_ch.seq_length, out_ch.repeat_times));
      end else begin
        oldest = owed_sequences.pop_front();
        if (out_ch.seq_bytes !== oldest.seq_bytes)
          report_bad($sformatf("seq_bytes %h, want %h", out_ch.seq_bytes, oldest.seq_bytes));
        if (out_ch.seq_length !== oldest.seq_length)
          report_bad($sformatf("seq_length %0d, want %0d",
                               out_ch.seq_length, oldest.seq_length));
        if (out_ch.repeat_times !== oldest.repeat_times)
          report_bad($sformatf("repeat_times %0d, want %0d",
                               out_ch.repeat_times, oldest.repeat_times));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    // known values on every input before the first edge
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = EV_KEY;
    in_ch.key_down      = 1'b0;
    in_ch.virtual_key   = '0;
    in_ch.modifier_bits = '0;
    in_ch.utf16_unit    = '0;
    in_ch.repeat_count  = '0;
    out_ch.ready        = 1'b0;
    held_high_half      = '0;

    // Directed table. Rows with a typed expectation are easy to read off:
    // ASCII corners, orphan low half, drops of every kind, the F1 corner.
    plan = '{
      typed_in(mk(EV_KEY, 1'b1, VK_A, '0, 16'h0041, 16'h0000),
               1'b1, 56'h41, 3'd1, 16'd1),
      typed_in(mk(EV_KEY, 1'b1, 8'h00, '0, 16'h007F, 16'hFFFF),
               1'b1, 56'h7F, 3'd1, 16'hFFFF),
      by_model(mk(EV_KEY, 1'b1, 8'h00, M_SHIFT, 16'h0080, 16'h0001)),
      typed_in(mk(EV_KEY, 1'b1, 8'h00, M_LALT, 16'hFFFF, 16'h0001),
               1'b1, 56'hBFBFEF1B, 3'd4, 16'd1),
      // low half with nothing held: replacement character
      typed_in(mk(EV_KEY, 1'b1, 8'h00, '0, 16'hDC00, 16'h0001),
               1'b1, 56'hBDBFEF, 3'd3, 16'd1),
      typed_in(mk(EV_KEY, 1'b1, 8'h00, '0, 16'hD800, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      by_model(mk(EV_KEY, 1'b1, 8'h00, '0, 16'hDC00, 16'h0003)),
      typed_in(mk(EV_KEY, 1'b1, 8'h00, '0, 16'hDBFF, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      by_model(mk(EV_KEY, 1'b1, 8'h00, M_RALT, 16'hDFFF, 16'h0001)),
      // non-key event with every field at its top
      typed_in(mk(EV_OTHER, 1'b1, 8'hFF, 9'h1FF, 16'hFFFF, 16'hFFFF),
               1'b0, 56'h0, 3'd0, 16'd0),
      // releases: plain is dropped, left alt or menu lets it through bare
      typed_in(mk(EV_KEY, 1'b0, VK_A, '0, 16'h0061, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      typed_in(mk(EV_KEY, 1'b0, VK_A, M_LALT, 16'h0061, 16'h0005),
               1'b1, 56'h61, 3'd1, 16'd5),
      typed_in(mk(EV_KEY, 1'b0, VK_MENU, '0, 16'h0062, 16'h0001),
               1'b1, 56'h62, 3'd1, 16'd1),
      // alt+numpad compose, with and without a character
      typed_in(mk(EV_KEY, 1'b1, VK_NUM4, M_LALT, 16'h0000, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      typed_in(mk(EV_KEY, 1'b1, VK_NUM0, M_LALT, 16'h0030, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      by_model(mk(EV_KEY, 1'b1, VK_UP, M_LALT | M_ENH, 16'h0000, 16'h0001)),
      by_model(mk(EV_KEY, 1'b1, VK_F12, M_RALT | M_LCTRL | M_SHIFT, 16'h0000, 16'h0001)),
      typed_in(mk(EV_KEY, 1'b1, VK_F1, '0, 16'h0000, 16'h0000),
               1'b1, 56'h415B5B1B, 3'd4, 16'd1),
      by_model(mk(EV_KEY, 1'b1, VK_DEL, M_LALT, 16'h0000, 16'h0001)),
      typed_in(mk(EV_KEY, 1'b1, VK_A, '0, 16'h0000, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      // ctrl suppresses the ESC on a character
      typed_in(mk(EV_KEY, 1'b1, VK_C, M_RALT | M_LCTRL, 16'h0063, 16'h0001),
               1'b1, 56'h63, 3'd1, 16'd1),
      // high half survives a function key in between
      typed_in(mk(EV_KEY, 1'b1, 8'h00, '0, 16'hDA00, 16'h0001),
               1'b0, 56'h0, 3'd0, 16'd0),
      by_model(mk(EV_KEY, 1'b1, VK_F5, M_SHIFT, 16'h0000, 16'h0001)),
      by_model(mk(EV_KEY, 1'b1, 8'h00, '0, 16'hDE00, 16'h0001)),
      by_model(mk(EV_KEY, 1'b1, VK_PAD_CENTER, M_SHIFT | M_RCTRL, 16'h0000, 16'h0009)),
      // longest sequence: seven bytes
      by_model(mk(EV_KEY, 1'b1, VK_INS, M_RALT | M_RCTRL | M_SHIFT, 16'h0000, 16'h0001))
    };

    // hold reset low before the directed table
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      send_key(plan[i].ev, plan[i].typed, plan[i].yields, plan[i].want);

    // random traffic; drop all idling for a stretch in the middle
    key_items = 0;
    while (key_items < RANDOM_KEYS) begin
      idle_pct = (key_items > 500 && key_items < 800) ? 0 : 18;
      random_burst();
    end
    idle_pct = 18;
    in_ch.valid <= 1'b0;

    // drain, then give the pipe time to show any stray item
    while (owed_sequences.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d directed rows, %0d random key events and %0d other events.",
             PLAN_ROWS, key_items, other_events);
    $display("Checked %0d sequences, including %0d surrogate pairs; %0d mismatches.",
             sequences_checked, surrogate_pairs, fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout: %0d sequences still owed", owed_sequences.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
